[sv/dtp_pkg.sv]
// Package with the shared types and character constants of the decimal text parser.
package dtp_pkg;

	// Character codes
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Magnitude saturates at 2^32; one bit above int32 magnitude
	localparam int MAG_W = 33;
	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, 32'h0};

	// Range limits for the final check
	localparam logic [MAG_W-1:0] LIM32_POS = 33'd2147483647;
	localparam logic [MAG_W-1:0] LIM32_NEG = 33'd2147483648;
	localparam logic [MAG_W-1:0] LIM16_POS = 33'd32767;
	localparam logic [MAG_W-1:0] LIM16_NEG = 33'd32768;

	// Configuration register indexes
	localparam logic [1:0] REG_STOP_LENGTH = 2'd0;
	localparam logic [1:0] REG_SKIP_ZEROS  = 2'd1;
	localparam logic [1:0] REG_NARROW      = 2'd2;

	typedef enum logic [2:0] {
		PH_START,
		PH_SIGNED,
		PH_ZERO_FIRST,
		PH_SKIPPING,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		VD_UNDECIDED,
		VD_OK,
		VD_FAIL
	} verdict_t;

	typedef struct packed {
		logic [7:0] stop_length;
		logic       skip_leading_zeros;
		logic       narrow_mode;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic [7:0]       pos;
		logic             neg;
		logic [MAG_W-1:0] mag;
		verdict_t         verdict;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:   PH_START,
		pos:     8'd0,
		neg:     1'b0,
		mag:     '0,
		verdict: VD_UNDECIDED
	};

endpackage

[sv/dtp_step.sv]
// Combinational step of the parser: next state and result for one character.
module dtp_step #(
	parameter int MAX_CHARS = 11
) (
	input  dtp_pkg::cfg_t         cfg,
	input  dtp_pkg::parse_state_t cur,
	input  logic [7:0]            char_code,
	output dtp_pkg::parse_state_t nxt,
	output logic                  term,
	output logic signed [31:0]    value,
	output logic                  ok
);

	localparam logic [7:0] LAST_POS = 8'(MAX_CHARS - 1);

	logic                        is_digit;
	logic [3:0]                  digit;
	logic                        stop_hit;
	logic                        too_far;
	logic [dtp_pkg::MAG_W+3:0]   mag_x10;
	logic [dtp_pkg::MAG_W-1:0]   mag_acc;
	logic                        good;
	logic [dtp_pkg::MAG_W-1:0]   mag_emit;
	logic [dtp_pkg::MAG_W-1:0]   limit;
	logic                        in_range;
	logic [31:0]                 mag_lo;
	dtp_pkg::parse_state_t       fd;

	// Classify the character and the position
	assign is_digit = (char_code >= dtp_pkg::CHAR_ZERO) && (char_code <= dtp_pkg::CHAR_NINE);
	assign digit    = char_code[3:0];
	assign stop_hit = (cfg.stop_length != 8'd0) &&
		(({1'b0, cur.pos} + 9'd1) >= {1'b0, cfg.stop_length});
	assign too_far  = cur.pos > LAST_POS;
	assign term     = char_code == dtp_pkg::CHAR_NUL;

	// Accumulate one decimal digit, saturated at 2^32
	always_comb begin
		mag_x10 = {1'b0, cur.mag, 3'b000} + {3'b000, cur.mag, 1'b0} +
			{{(dtp_pkg::MAG_W){1'b0}}, digit};
		if (mag_x10 > {4'b0000, dtp_pkg::MAG_CAP}) begin
			mag_acc = dtp_pkg::MAG_CAP;
		end else begin
			mag_acc = mag_x10[dtp_pkg::MAG_W-1:0];
		end
	end

	// Take the first significant digit
	always_comb begin
		fd = cur;
		if (!is_digit) begin
			fd.phase   = dtp_pkg::PH_DONE;
			fd.verdict = dtp_pkg::VD_FAIL;
		end else begin
			fd.mag = {{(dtp_pkg::MAG_W-4){1'b0}}, digit};
			if (stop_hit) begin
				fd.phase   = dtp_pkg::PH_DONE;
				fd.verdict = dtp_pkg::VD_OK;
			end else begin
				fd.phase = dtp_pkg::PH_DIGITS;
			end
		end
	end

	// Advance the parse state
	always_comb begin
		nxt      = cur;
		good     = 1'b0;
		mag_emit = cur.mag;
		if (term) begin
			unique case (cur.phase)
				dtp_pkg::PH_ZERO_FIRST: begin
					mag_emit = '0;
					good     = 1'b1;
				end
				dtp_pkg::PH_SKIPPING: begin
					mag_emit = '0;
					good     = !too_far;
				end
				dtp_pkg::PH_DIGITS: good = 1'b1;
				dtp_pkg::PH_DONE:   good = cur.verdict == dtp_pkg::VD_OK;
				default:            good = 1'b0;
			endcase
			nxt = dtp_pkg::STATE_RESET;
		end else begin
			unique case (cur.phase)
				dtp_pkg::PH_START, dtp_pkg::PH_SIGNED: begin
					if (cur.phase == dtp_pkg::PH_START && char_code == dtp_pkg::CHAR_MINUS) begin
						nxt.neg   = 1'b1;
						nxt.phase = dtp_pkg::PH_SIGNED;
					end else if (char_code == dtp_pkg::CHAR_ZERO) begin
						nxt.mag = '0;
						if (cfg.stop_length == 8'd1) begin
							nxt.phase   = dtp_pkg::PH_DONE;
							nxt.verdict = dtp_pkg::VD_OK;
						end else begin
							nxt.phase = dtp_pkg::PH_ZERO_FIRST;
						end
					end else begin
						nxt = fd;
					end
				end
				dtp_pkg::PH_ZERO_FIRST, dtp_pkg::PH_SKIPPING: begin
					if ((cur.phase == dtp_pkg::PH_ZERO_FIRST && !cfg.skip_leading_zeros) ||
						too_far) begin
						nxt.phase   = dtp_pkg::PH_DONE;
						nxt.verdict = dtp_pkg::VD_FAIL;
					end else if (char_code == dtp_pkg::CHAR_ZERO) begin
						nxt.phase = dtp_pkg::PH_SKIPPING;
					end else begin
						nxt = fd;
					end
				end
				dtp_pkg::PH_DIGITS: begin
					if (too_far || !is_digit) begin
						nxt.phase   = dtp_pkg::PH_DONE;
						nxt.verdict = dtp_pkg::VD_FAIL;
					end else begin
						nxt.mag = mag_acc;
						if (stop_hit) begin
							nxt.phase   = dtp_pkg::PH_DONE;
							nxt.verdict = dtp_pkg::VD_OK;
						end
					end
				end
				default: ;
			endcase
			// Saturate the position counter
			nxt.pos = (cur.pos == 8'hff) ? cur.pos : cur.pos + 8'd1;
		end
	end

	// Check the range and form the signed result
	always_comb begin
		if (cfg.narrow_mode) begin
			limit = cur.neg ? dtp_pkg::LIM16_NEG : dtp_pkg::LIM16_POS;
		end else begin
			limit = cur.neg ? dtp_pkg::LIM32_NEG : dtp_pkg::LIM32_POS;
		end
		in_range = mag_emit <= limit;
		mag_lo   = mag_emit[31:0];
		ok       = good && in_range;
		if (!ok) begin
			value = '0;
		end else if (cur.neg) begin
			value = signed'(32'd0 - mag_lo);
		end else begin
			value = signed'(mag_lo);
		end
	end

endmodule

[sv/decimal_text_to_int_parser.sv]
// Top level of the streaming decimal text to integer parser.
//
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   char_code[7:0]
// output   out        out_valid / out_stall value[31:0] signed, ok
// config   in         cfg_we                cfg_index[1:0], cfg_data[7:0]
//
// One character is taken per cycle while in_stall is low; a terminating byte
// passes the character register, then loads the result register. Each holds
// one transaction, so bytes keep flowing while a result waits.
// A terminator stalls in the character register only while the result register
// is full and stalled. Reset clears the parse state, the config and all valids.
module decimal_text_to_int_parser #(
	parameter int MAX_CHARS = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               ok,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	dtp_pkg::cfg_t         cfg_q;
	dtp_pkg::parse_state_t state_q;
	dtp_pkg::parse_state_t state_nxt;
	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  out_valid_q;
	logic signed [31:0]    value_q;
	logic                  ok_q;
	logic                  term;
	logic signed [31:0]    step_value;
	logic                  step_ok;
	logic                  out_free;
	logic                  proc;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dtp_pkg::REG_STOP_LENGTH: cfg_q.stop_length        <= cfg_data;
				dtp_pkg::REG_SKIP_ZEROS:  cfg_q.skip_leading_zeros <= cfg_data[0];
				dtp_pkg::REG_NARROW:      cfg_q.narrow_mode        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dtp_step #(
		.MAX_CHARS(MAX_CHARS)
	) u_step (
		.cfg(cfg_q),
		.cur(state_q),
		.char_code(char_s1),
		.nxt(state_nxt),
		.term(term),
		.value(step_value),
		.ok(step_ok)
	);

	// Process the held character unless its result has nowhere to go
	assign out_free = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && (!term || out_free);
	assign in_stall = valid_s1 && !proc;

	// Hold the input character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
		end
	end

	// Advance the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtp_pkg::STATE_RESET;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	// Load the result register on a terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc && term;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && proc && term) begin
			value_q <= step_value;
			ok_q    <= step_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign ok        = ok_q;

endmodule

[bench/parse_result_check.sv]
// Checker that predicts the parser's results from observed transactions and compares them.
module parse_result_check #(
	parameter int MAX_CHARS = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] value,
	input  logic               ok,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output int                 errors,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] LAST_POS = 8'(MAX_CHARS - 1);

	typedef struct {
		logic signed [31:0] value;
		logic               ok;
	} parse_result_t;

	parse_result_t pending_results[$];

	// Shadow copy of the configuration registers
	logic [7:0] stop_len;
	logic       skip_zeros;
	logic       narrow;

	// Shadow copy of the parse state
	dtp_pkg::phase_t           phase;
	logic [7:0]                pos;
	logic                      neg;
	logic [dtp_pkg::MAG_W-1:0] mag;
	dtp_pkg::verdict_t         verdict;

	function automatic logic is_digit(logic [7:0] c);
		return c >= dtp_pkg::CHAR_ZERO && c <= dtp_pkg::CHAR_NINE;
	endfunction

	// True once the character at position q is the last one to convert
	function automatic logic stop_after(logic [7:0] q);
		return stop_len != 8'd0 && ({1'b0, q} + 9'd1) >= {1'b0, stop_len};
	endfunction

	function automatic void settle(dtp_pkg::verdict_t v);
		phase = dtp_pkg::PH_DONE;
		verdict = v;
	endfunction

	function automatic void take_first_digit(logic [7:0] q, logic [7:0] c);
		if (!is_digit(c)) begin
			settle(dtp_pkg::VD_FAIL);
		end else begin
			mag = {{(dtp_pkg::MAG_W-8){1'b0}}, c - dtp_pkg::CHAR_ZERO};
			if (stop_after(q))
				settle(dtp_pkg::VD_OK);
			else
				phase = dtp_pkg::PH_DIGITS;
		end
	endfunction

	function automatic void skip_step(logic [7:0] q, logic [7:0] c);
		if (q > LAST_POS)
			settle(dtp_pkg::VD_FAIL);
		else if (c == dtp_pkg::CHAR_ZERO)
			phase = dtp_pkg::PH_SKIPPING;
		else
			take_first_digit(q, c);
	endfunction

	function automatic void clear_parse();
		phase = dtp_pkg::PH_START;
		pos = 8'd0;
		neg = 1'b0;
		mag = '0;
		verdict = dtp_pkg::VD_UNDECIDED;
	endfunction

	// Advance the parse by one character; return 1 when it yields a result
	function automatic logic parse_char(input logic [7:0] c, output parse_result_t res);
		logic [7:0]                q;
		logic                      good;
		logic [dtp_pkg::MAG_W-1:0] limit;
		logic [36:0]               grown;
		q = pos;
		res.value = '0;
		res.ok = 1'b0;
		if (c == dtp_pkg::CHAR_NUL) begin
			case (phase)
				dtp_pkg::PH_ZERO_FIRST: begin
					mag = '0;
					good = 1'b1;
				end
				dtp_pkg::PH_SKIPPING: begin
					mag = '0;
					good = (q <= LAST_POS);
				end
				dtp_pkg::PH_DIGITS: good = 1'b1;
				dtp_pkg::PH_DONE: good = (verdict == dtp_pkg::VD_OK);
				default: good = 1'b0;
			endcase
			if (narrow)
				limit = neg ? dtp_pkg::LIM16_NEG : dtp_pkg::LIM16_POS;
			else
				limit = neg ? dtp_pkg::LIM32_NEG : dtp_pkg::LIM32_POS;
			if (good && mag <= limit) begin
				res.value = neg ? 32'd0 - mag[31:0] : mag[31:0];
				res.ok = 1'b1;
			end
			clear_parse();
			return 1'b1;
		end
		case (phase)
			dtp_pkg::PH_START, dtp_pkg::PH_SIGNED: begin
				if (phase == dtp_pkg::PH_START && c == dtp_pkg::CHAR_MINUS) begin
					neg = 1'b1;
					phase = dtp_pkg::PH_SIGNED;
				end else if (c == dtp_pkg::CHAR_ZERO) begin
					mag = '0;
					if (stop_len == 8'd1)
						settle(dtp_pkg::VD_OK);
					else
						phase = dtp_pkg::PH_ZERO_FIRST;
				end else begin
					take_first_digit(q, c);
				end
			end
			dtp_pkg::PH_ZERO_FIRST: begin
				if (!skip_zeros)
					settle(dtp_pkg::VD_FAIL);
				else
					skip_step(q, c);
			end
			dtp_pkg::PH_SKIPPING: skip_step(q, c);
			dtp_pkg::PH_DIGITS: begin
				if (q > LAST_POS || !is_digit(c)) begin
					settle(dtp_pkg::VD_FAIL);
				end else begin
					// Saturate the magnitude at 2^32, one bit above int32 magnitude
					grown = {{(37-dtp_pkg::MAG_W){1'b0}}, mag} * 37'd10 +
						{29'd0, c - dtp_pkg::CHAR_ZERO};
					mag = (grown > {{(37-dtp_pkg::MAG_W){1'b0}}, dtp_pkg::MAG_CAP}) ?
						dtp_pkg::MAG_CAP : grown[dtp_pkg::MAG_W-1:0];
					if (stop_after(q))
						settle(dtp_pkg::VD_OK);
				end
			end
			default: ;
		endcase
		if (pos != 8'd255)
			pos = pos + 8'd1;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t expected_item;
		if (!arst_n) begin
			stop_len = 8'd0;
			skip_zeros = 1'b0;
			narrow = 1'b0;
			clear_parse();
			pending_results.delete();
			errors = 0;
		end else begin
			// Compare a delivered result with the oldest expectation
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					$error("unexpected result transaction: value=%0d ok=%0b", value, ok);
				end else begin
					expected_item = pending_results.pop_front();
					if (value !== expected_item.value) begin
						errors++;
						$error("value: expected %0d, got %0d", expected_item.value, value);
					end
					if (ok !== expected_item.ok) begin
						errors++;
						$error("ok: expected %0b, got %0b", expected_item.ok, ok);
					end
				end
			end
			// Predict from an accepted character
			if (in_valid && !in_stall) begin
				if (parse_char(char_code, expected_item))
					pending_results.push_back(expected_item);
			end
			// Track register writes; they apply from the next character on
			if (cfg_we) begin
				case (cfg_index)
					dtp_pkg::REG_STOP_LENGTH: stop_len = cfg_data;
					dtp_pkg::REG_SKIP_ZEROS: skip_zeros = cfg_data[0];
					dtp_pkg::REG_NARROW: narrow = cfg_data[0];
					default: ;
				endcase
			end
		end
		outstanding = pending_results.size();
	end

endmodule

[bench/tb.sv]
// Bench top: drives characters, register writes and result stalls, and reports the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHARS = 11;
	localparam int ITEM_TARGET = 2000;
	localparam int STRINGS_PER_SETTING = 10;
	localparam int DRAIN_CYCLES = 6;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_code = 8'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] value;
	logic               ok;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = 2'd0;
	logic [7:0]         cfg_data = 8'd0;

	int errors;
	int outstanding;
	int tx_idle_pct = 34;
	int rx_idle_pct = 88;
	int chars_sent = 0;
	int idle_cycles = 0;
	logic [7:0] text[$];
	longint range_edges [10] = '{64'd32767, 64'd32768, 64'd2147483647, 64'd2147483648,
		64'd4294967295, 64'd4294967296, 64'd9999999999, 64'd99999999999,
		64'd42949672960, 64'd1};

	decimal_text_to_int_parser #(
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.ok(ok),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	parse_result_check #(
		.MAX_CHARS(MAX_CHARS)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.ok(ok),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// Stall the result channel at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one character after a random gap and hold it until taken
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text[i])
			send_char(text[i]);
		send_char(dtp_pkg::CHAR_NUL);
	endtask

	task automatic load_text(input string s);
		text.delete();
		foreach (s[i])
			text.push_back(s[i]);
	endtask

	// Drop valid and wait until every result is out and the pipeline is empty
	task automatic drain_to_idle();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] stop, input logic skip, input logic narrow);
		drain_to_idle();
		write_reg(dtp_pkg::REG_STOP_LENGTH, stop);
		write_reg(dtp_pkg::REG_SKIP_ZEROS, {7'($urandom), skip});
		write_reg(dtp_pkg::REG_NARROW, {7'($urandom), narrow});
		if ($urandom_range(3) == 0)
			write_reg(REG_SPARE, 8'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Build one string: mostly numbers, some near limits, zero runs, corruption and noise
	task automatic build_random_text();
		int     kind;
		int     delta;
		longint mag;
		string  digits;
		text.delete();
		kind = $urandom_range(99);
		if (kind < 90 && $urandom_range(2) == 0)
			text.push_back(dtp_pkg::CHAR_MINUS);
		if (kind < 55) begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 4)) text.push_back(dtp_pkg::CHAR_ZERO);
			repeat ($urandom_range(1, 12))
				text.push_back(8'(dtp_pkg::CHAR_ZERO + $urandom_range(9)));
		end else if (kind < 70) begin
			delta = int'($urandom_range(2)) - 1;
			mag = range_edges[$urandom_range(9)] + delta;
			digits = $sformatf("%0d", mag);
			foreach (digits[i])
				text.push_back(digits[i]);
		end else if (kind < 80) begin
			repeat ($urandom_range(1, 14)) text.push_back(dtp_pkg::CHAR_ZERO);
			repeat ($urandom_range(3))
				text.push_back(8'(dtp_pkg::CHAR_ZERO + $urandom_range(9)));
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 8))
				text.push_back(8'(dtp_pkg::CHAR_ZERO + $urandom_range(9)));
			text[$urandom_range(text.size() - 1)] = 8'($urandom_range(1, 255));
		end else begin
			repeat ($urandom_range(14)) text.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	initial begin
		int seg;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed strings: empty, lone sign, zero, negative zero, junk after a failure,
		// saturating magnitude
		apply_setting(8'd0, 1'b0, 1'b0);
		load_text("");
		send_text();
		load_text("-");
		send_text();
		load_text("0");
		send_text();
		load_text("-0");
		send_text();
		load_text("7\3775");
		send_text();
		load_text("99999999999");
		send_text();

		// Random strings under a sequence of settings
		seg = 0;
		while (chars_sent < ITEM_TARGET) begin
			case (chars_sent * 3 / ITEM_TARGET)
				0: begin
					tx_idle_pct = 34;
					rx_idle_pct = 88;
				end
				1: begin
					tx_idle_pct = 88;
					rx_idle_pct = 34;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (seg % 6)
				0: apply_setting(8'd0, 1'($urandom), 1'($urandom));
				1: apply_setting(8'd255, 1'($urandom), 1'($urandom));
				2: apply_setting(8'd1, 1'($urandom), 1'($urandom));
				3: apply_setting(8'($urandom_range(2, 13)), 1'($urandom), 1'($urandom));
				4: apply_setting(8'($urandom), 1'($urandom), 1'($urandom));
				default: apply_setting(8'd0, 1'b1, 1'b1);
			endcase
			for (int k = 0; k < STRINGS_PER_SETTING; k++) begin
				if (seg == 3 && k == 0) begin
					// Long digit string that runs the position counter into saturation
					text.delete();
					repeat (260) text.push_back(8'(dtp_pkg::CHAR_ZERO + $urandom_range(9)));
				end else begin
					build_random_text();
				end
				send_text();
			end
			seg++;
		end

		drain_to_idle();
		if (errors == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
sv/dtp_pkg.sv
sv/dtp_step.sv
sv/decimal_text_to_int_parser.sv
bench/parse_result_check.sv
bench/tb.sv
